// File: hdl/sm83_pkg.sv
// ----------------------------------------------------------------------------
// sm83_pkg
// Types and constants shared by the register-move and ALU execute block.
// ----------------------------------------------------------------------------
package sm83_pkg;

	// Register file index, entries B, C, D, E, H, L, A.
	localparam int REG_COUNT = 7;
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t IDX_B = 3'd0;
	localparam reg_idx_t IDX_H = 3'd4;
	localparam reg_idx_t IDX_L = 3'd5;
	localparam reg_idx_t IDX_A = 3'd6;

	// Operand selector codes from the opcode fields.
	localparam logic [2:0] SEL_MEM = 3'd6;
	localparam logic [2:0] SEL_A   = 3'd7;

	// Opcode range limits and the one hole in the load block.
	localparam logic [7:0] OP_FIRST = 8'h40;
	localparam logic [7:0] OP_LAST  = 8'hBF;
	localparam logic [7:0] OP_HALT  = 8'h76;

	typedef logic [REG_COUNT-1:0][7:0] reg_file_t;

	// ALU operations selected by opcode bits 5..3.
	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_ADC = 3'd1,
		ALU_SUB = 3'd2,
		ALU_SBC = 3'd3,
		ALU_AND = 3'd4,
		ALU_XOR = 3'd5,
		ALU_OR  = 3'd6,
		ALU_CP  = 3'd7
	} alu_op_t;

	// Flag bit positions within the flag nibble.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] mem_data;
	} in_item_t;

	typedef struct packed {
		logic        mem_write;
		logic [15:0] mem_addr;
		logic [7:0]  mem_wdata;
		logic [7:0]  acc_value;
		logic [3:0]  flag_bits;
		logic [15:0] pc_value;
		logic        unhandled;
	} out_item_t;

	// State update decided by the execute logic for one instruction.
	typedef struct packed {
		logic       unhandled;
		logic       reg_we;
		reg_idx_t   reg_idx;
		logic [7:0] reg_wdata;
		logic       flags_we;
		logic [3:0] flags_next;
		logic       mem_write;
		logic [7:0] mem_wdata;
	} exec_t;

endpackage

// File: hdl/sm83_if.sv
// ----------------------------------------------------------------------------
// sm83 channel interfaces
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface sm83_in_if
	import sm83_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sm83_out_if
	import sm83_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sm83_alu.sv
// ----------------------------------------------------------------------------
// sm83_alu
// Decodes one opcode and works out the register, flag and memory update.
// ----------------------------------------------------------------------------
module sm83_alu
	import sm83_pkg::*;
(
	input  logic [7:0] opcode,
	input  logic [7:0] mem_data,
	input  reg_file_t  regs,
	input  logic [3:0] flags,
	output exec_t      exec
);

	logic [2:0] dst_sel;
	logic [2:0] src_sel;
	reg_idx_t   src_idx;
	reg_idx_t   dst_idx;
	logic [7:0] src;
	logic [7:0] acc;
	logic       cin;
	logic       carry_in;
	alu_op_t    op;
	logic [8:0] sum;
	logic [4:0] half_sum;
	logic [8:0] diff;
	logic [4:0] half_diff;
	logic [7:0] res;
	logic [3:0] f;
	logic       bad;

	assign dst_sel = opcode[5:3];
	assign src_sel = opcode[2:0];
	assign op      = alu_op_t'(opcode[5:3]);
	assign acc     = regs[IDX_A];
	assign cin     = flags[FLAG_C];

	// Selector seven names A, which sits at index six in the file.
	assign src_idx = (src_sel == SEL_A) ? IDX_A : src_sel;
	assign dst_idx = (dst_sel == SEL_A) ? IDX_A : dst_sel;
	assign src     = (src_sel == SEL_MEM) ? mem_data : regs[src_idx];

	assign bad = (opcode < OP_FIRST) || (opcode > OP_LAST) || (opcode == OP_HALT);

	// Carry enters only for ADC and SBC.
	assign carry_in = ((op == ALU_ADC) || (op == ALU_SBC)) ? cin : 1'b0;

	assign sum       = {1'b0, acc} + {1'b0, src} + {8'd0, carry_in};
	assign half_sum  = {1'b0, acc[3:0]} + {1'b0, src[3:0]} + {4'd0, carry_in};
	assign diff      = {1'b0, acc} - {1'b0, src} - {8'd0, carry_in};
	assign half_diff = {1'b0, acc[3:0]} - {1'b0, src[3:0]} - {4'd0, carry_in};

	// Result and flags of the ALU operation.
	always_comb begin
		f = 4'd0;
		unique case (op)
			ALU_ADD, ALU_ADC: begin
				res       = sum[7:0];
				f[FLAG_H] = half_sum[4];
				f[FLAG_C] = sum[8];
			end
			ALU_SUB, ALU_SBC, ALU_CP: begin
				res       = diff[7:0];
				f[FLAG_N] = 1'b1;
				f[FLAG_H] = half_diff[4];
				f[FLAG_C] = diff[8];
			end
			ALU_AND: begin
				res       = acc & src;
				f[FLAG_H] = 1'b1;
			end
			ALU_XOR: res = acc ^ src;
			ALU_OR:  res = acc | src;
			default: res = acc | src;
		endcase
		f[FLAG_Z] = (res == 8'd0);
	end

	// Combine the load and ALU paths into one state update.
	always_comb begin
		exec            = '0;
		exec.unhandled  = bad;
		exec.flags_next = f;
		if (!bad) begin
			if (!opcode[7]) begin
				if (dst_sel == SEL_MEM) begin
					exec.mem_write = 1'b1;
					exec.mem_wdata = src;
				end else begin
					exec.reg_we    = 1'b1;
					exec.reg_idx   = dst_idx;
					exec.reg_wdata = src;
				end
			end else begin
				exec.flags_we  = 1'b1;
				exec.reg_we    = (op != ALU_CP);
				exec.reg_idx   = IDX_A;
				exec.reg_wdata = res;
			end
		end
	end

endmodule

// File: hdl/sm83_register_load_and_alu_execute.sv
// ----------------------------------------------------------------------------
// sm83_register_load_and_alu_execute
// Register-move and 8-bit ALU execute stage for opcodes 0x40 to 0xBF.
// ----------------------------------------------------------------------------
// The block retires one instruction per clock while the sink is ready. An
// accepted transaction lands in the instruction register; in the following
// cycle the decode and ALU logic works on it in one pass and, as it moves
// into the result register, the register file, flags and program counter
// are updated, so the next instruction in the instruction register already
// sees the new state. The result register is refilled in the same cycle it
// is taken, so a ready sink sees one result every clock; a stalled sink
// holds both registers and the input ready drops only when both are full.
module sm83_register_load_and_alu_execute
	import sm83_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	sm83_in_if.sink    instr,
	sm83_out_if.source result
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       valid_s2;
	out_item_t  item_s2;
	reg_file_t  regs_q;
	logic [3:0] flags_q;
	logic [15:0] pc_q;

	exec_t       exec;
	logic        advance;
	logic [7:0]  acc_next;
	logic [3:0]  flags_next;
	logic [15:0] pc_next;

	// Handshake: the instruction moves on when the result slot is free or
	// being emptied.
	assign advance     = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready = !valid_s1 || advance;

	sm83_alu u_alu (
		.opcode   (item_s1.opcode),
		.mem_data (item_s1.mem_data),
		.regs     (regs_q),
		.flags    (flags_q),
		.exec     (exec)
	);

	// State after the instruction, as reported in the result.
	assign acc_next   = (exec.reg_we && (exec.reg_idx == IDX_A)) ? exec.reg_wdata
	                                                             : regs_q[IDX_A];
	assign flags_next = exec.flags_we ? exec.flags_next : flags_q;
	assign pc_next    = exec.unhandled ? pc_q : pc_q + 16'd1;

	// Instruction register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	// Instruction register payload.
	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			item_s1 <= instr.data;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2.mem_write <= exec.mem_write;
			item_s2.mem_addr  <= {regs_q[IDX_H], regs_q[IDX_L]};
			item_s2.mem_wdata <= exec.mem_wdata;
			item_s2.acc_value <= acc_next;
			item_s2.flag_bits <= flags_next;
			item_s2.pc_value  <= pc_next;
			item_s2.unhandled <= exec.unhandled;
		end
	end

	// Architectural state, updated as each instruction executes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q  <= '0;
			flags_q <= 4'd0;
			pc_q    <= 16'd0;
		end else if (advance) begin
			if (exec.reg_we) begin
				regs_q[exec.reg_idx] <= exec.reg_wdata;
			end
			flags_q <= flags_next;
			pc_q    <= pc_next;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = item_s2;

	// An unhandled opcode leaves the flags and program counter alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && exec.unhandled |=> $stable(pc_q) && $stable(flags_q))
		else $error("unhandled opcode changed architectural state");

	// A handled opcode advances the program counter by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !exec.unhandled |=> pc_q == $past(pc_q) + 16'd1)
		else $error("program counter did not advance");

	// A pending result never reports a store for an unhandled opcode.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && item_s2.unhandled |-> !item_s2.mem_write)
		else $error("store reported for unhandled opcode");

	// Write data is zero whenever no store is made.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !item_s2.mem_write |-> item_s2.mem_wdata == 8'd0)
		else $error("write data set without a store");

	// A store never touches the register file.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && exec.mem_write |=> $stable(regs_q))
		else $error("store altered the register file");

endmodule
